FILE: sv/cdr_pkg.sv
`timescale 1ns / 1ps

package cdr_pkg;

	localparam int MAX_MESSAGE_DEF = 512;

	localparam logic [7:0] FLAGS_HI     = 8'h81;
	localparam logic [7:0] FLAGS_LO     = 8'h80;
	localparam logic [7:0] NAME_PTR_HI  = 8'hC0;
	localparam logic [7:0] NAME_PTR_LO  = 8'h0C;
	localparam logic [7:0] RR_TYPE_A    = 8'h01;
	localparam logic [7:0] RR_CLASS_IN  = 8'h01;
	localparam logic [7:0] RDLENGTH_V4  = 8'h04;
	localparam int         HEADER_BYTES = 12;
	localparam int         ANSWER_BYTES = 16;

	localparam logic [31:0] ADDRESS_RESET = 32'hC0A8_0401;
	localparam logic [31:0] TTL_RESET     = 32'd60;

	localparam logic REG_ANSWER_ADDRESS = 1'b0;
	localparam logic REG_ANSWER_TTL     = 1'b1;

	typedef enum logic [2:0] {
		PH_HEADER,
		PH_LEN,
		PH_LABEL,
		PH_TAIL,
		PH_SWALLOW
	} phase_t;

	typedef struct packed {
		logic       valid;
		logic [7:0] data;
		logic       last;
		logic       drop;
		logic       ans;
	} res_t;

	function automatic logic [7:0] ans_byte(input logic [3:0] idx, input logic [31:0] ttl,
		input logic [31:0] addr);
		logic [7:0] b;
		case (idx)
			4'd0:    b = NAME_PTR_HI;
			4'd1:    b = NAME_PTR_LO;
			4'd2:    b = 8'h00;
			4'd3:    b = RR_TYPE_A;
			4'd4:    b = 8'h00;
			4'd5:    b = RR_CLASS_IN;
			4'd6:    b = ttl[31:24];
			4'd7:    b = ttl[23:16];
			4'd8:    b = ttl[15:8];
			4'd9:    b = ttl[7:0];
			4'd10:   b = 8'h00;
			4'd11:   b = RDLENGTH_V4;
			4'd12:   b = addr[31:24];
			4'd13:   b = addr[23:16];
			4'd14:   b = addr[15:8];
			default: b = addr[7:0];
		endcase
		return b;
	endfunction

endpackage

FILE: sv/captive_dns_responder.sv
`timescale 1ns / 1ps

// Rewrites a DNS query, one byte per beat, into a captive-portal A-record
// response. Each query byte moves through an input register and then the
// response register. Header and question bytes map one-to-one onto
// response beats; the class byte closing the question is followed by the
// 16-byte answer, which the response register streams out from the answer
// sequencer, so that byte holds the input for 17 output beats. Bytes after
// the question, or after a drop beat, are consumed at one per cycle while
// the response register is free, with no output. A drop beat (out_drop,
// out_last, out_byte zero) tells the sink to discard the frame. Write
// answer_address and answer_ttl only while no frame is in flight.
module captive_dns_responder import cdr_pkg::*; #(
	parameter int MAX_MESSAGE = MAX_MESSAGE_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  in_byte,
	input  logic        in_last,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic        out_last,
	output logic        out_drop,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data
);

	logic [31:0] address_q;
	logic [31:0] ttl_q;
	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic        out_last_q;
	logic        out_drop_q;
	logic        ans_active_q;
	logic [3:0]  ans_idx_q;
	logic        out_free;
	logic        out_beat;
	res_t        res;

	assign out_beat = out_valid_q && out_ready;
	assign out_free = !ans_active_q && (!out_valid_q || out_ready);

	cdr_parse #(
		.MAX_MESSAGE(MAX_MESSAGE)
	) u_parse (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_byte  (in_byte),
		.in_last  (in_last),
		.out_free (out_free),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			address_q <= ADDRESS_RESET;
			ttl_q     <= TTL_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ANSWER_ADDRESS: address_q <= cfg_data;
				REG_ANSWER_TTL:     ttl_q     <= cfg_data;
				default:            ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			ans_active_q <= 1'b0;
			ans_idx_q    <= '0;
		end else if (res.valid) begin
			out_valid_q  <= 1'b1;
			ans_active_q <= res.ans;
			ans_idx_q    <= '0;
		end else if (out_beat) begin
			out_valid_q <= ans_active_q;
			if (ans_active_q) begin
				ans_idx_q <= ans_idx_q + 4'd1;
				if (ans_idx_q == 4'(ANSWER_BYTES - 1))
					ans_active_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid) begin
			out_byte_q <= res.data;
			out_last_q <= res.last;
			out_drop_q <= res.drop;
		end else if (out_beat && ans_active_q) begin
			out_byte_q <= ans_byte(ans_idx_q, ttl_q, address_q);
			out_last_q <= (ans_idx_q == 4'(ANSWER_BYTES - 1));
			out_drop_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign out_last  = out_last_q;
	assign out_drop  = out_drop_q;

`ifndef SYNTHESIS
	a_drop_beat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_drop_q |-> out_last_q && out_byte_q == 8'h00)
		else $error("drop beat is not a zero last beat");

	a_ans_refill: assert property (@(posedge clk) disable iff (!arst_n)
		out_beat && ans_active_q |=> out_valid_q && !out_drop_q)
		else $error("answer sequence lost a beat");

	a_ans_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!ans_active_q |-> ans_idx_q == 4'd0 || ans_idx_q == 4'(ANSWER_BYTES))
		else $error("answer index left mid-sequence");

	a_ans_stall: assert property (@(posedge clk) disable iff (!arst_n)
		ans_active_q |-> !res.valid)
		else $error("parser advanced during answer");
`endif

endmodule

FILE: sv/cdr_parse.sv
`timescale 1ns / 1ps

module cdr_parse import cdr_pkg::*; #(
	parameter int MAX_MESSAGE = MAX_MESSAGE_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	input  logic       out_free,
	output res_t       res
);

	localparam int POS_W = $clog2(MAX_MESSAGE + 1);
	localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(MAX_MESSAGE - ANSWER_BYTES);
	localparam logic [POS_W-1:0] POS_HDR_END = POS_W'(HEADER_BYTES - 1);

	logic             v_s1;
	logic [7:0]       byte_s1;
	logic             last_s1;
	logic             advance;

	logic [POS_W-1:0] pos_q, pos_d, pos_inc;
	phase_t           phase_q, phase_d;
	logic [7:0]       label_q, label_d, label_dec;
	logic [7:0]       qch_q, qch_d;
	logic [1:0]       tail_q, tail_d;
	logic [7:0]       hdr_byte;
	logic             tail_done;

	assign advance  = v_s1 && out_free;
	assign in_ready = !v_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
			last_s1 <= in_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			phase_q <= PH_HEADER;
			label_q <= '0;
			qch_q   <= '0;
			tail_q  <= '0;
		end else if (advance) begin
			pos_q   <= pos_d;
			phase_q <= phase_d;
			label_q <= label_d;
			qch_q   <= qch_d;
			tail_q  <= tail_d;
		end
	end

	always_comb begin
		pos_inc   = (pos_q == '1) ? pos_q : pos_q + POS_W'(1);
		label_dec = label_q - 8'd1;
		pos_d     = pos_inc;
		phase_d   = phase_q;
		label_d   = label_q;
		qch_d     = qch_q;
		tail_d    = tail_q;
		tail_done = 1'b0;
		res       = '0;

		hdr_byte = byte_s1;
		if (pos_q == POS_W'(2))
			hdr_byte = FLAGS_HI;
		else if (pos_q == POS_W'(3))
			hdr_byte = FLAGS_LO;
		else if (pos_q == POS_W'(6) || (pos_q >= POS_W'(8) && pos_q <= POS_HDR_END))
			hdr_byte = 8'h00;
		else if (pos_q == POS_W'(7))
			hdr_byte = 8'h01;

		if (phase_q == PH_SWALLOW) begin
			if (last_s1) begin
				phase_d = PH_HEADER;
				pos_d   = '0;
			end
		end else if (phase_q == PH_HEADER) begin
			if (last_s1) begin
				res     = '{valid: 1'b1, data: 8'h00, last: 1'b1, drop: 1'b1, ans: 1'b0};
				phase_d = PH_HEADER;
				pos_d   = '0;
			end else if (pos_q == POS_W'(5) && qch_q == 8'h00 && byte_s1 == 8'h00) begin
				res     = '{valid: 1'b1, data: 8'h00, last: 1'b1, drop: 1'b1, ans: 1'b0};
				phase_d = PH_SWALLOW;
			end else begin
				if (pos_q == POS_W'(4))
					qch_d = byte_s1;
				if (pos_q >= POS_HDR_END)
					phase_d = PH_LEN;
				res = '{valid: 1'b1, data: hdr_byte, last: 1'b0, drop: 1'b0, ans: 1'b0};
			end
		end else if (pos_q >= POS_LIMIT) begin
			res = '{valid: 1'b1, data: 8'h00, last: 1'b1, drop: 1'b1, ans: 1'b0};
			if (last_s1) begin
				phase_d = PH_HEADER;
				pos_d   = '0;
			end else begin
				phase_d = PH_SWALLOW;
			end
		end else begin
			unique case (phase_q)
				PH_LEN: begin
					if (byte_s1 == 8'h00) begin
						phase_d = PH_TAIL;
						tail_d  = '0;
					end else begin
						label_d = byte_s1;
						phase_d = PH_LABEL;
					end
				end
				PH_LABEL: begin
					label_d = label_dec;
					if (label_dec == 8'h00)
						phase_d = PH_LEN;
				end
				PH_TAIL: begin
					if (tail_q == 2'd3) begin
						tail_done = 1'b1;
						tail_d    = '0;
						res = '{valid: 1'b1, data: byte_s1, last: 1'b0, drop: 1'b0, ans: 1'b1};
						if (last_s1) begin
							phase_d = PH_HEADER;
							pos_d   = '0;
						end else begin
							phase_d = PH_SWALLOW;
						end
					end else begin
						tail_d = tail_q + 2'd1;
					end
				end
				default: phase_d = PH_HEADER;
			endcase
			if (!tail_done) begin
				if (last_s1) begin
					res     = '{valid: 1'b1, data: 8'h00, last: 1'b1, drop: 1'b1, ans: 1'b0};
					phase_d = PH_HEADER;
					pos_d   = '0;
				end else begin
					res = '{valid: 1'b1, data: byte_s1, last: 1'b0, drop: 1'b0, ans: 1'b0};
				end
			end
		end

		res.valid = res.valid && advance;
	end

endmodule

FILE: tb/captive_dns_responder_test.sv
`timescale 1ns / 1ps

module captive_dns_responder_test;
	import cdr_pkg::*;

	localparam int MSG_LIMIT   = MAX_MESSAGE_DEF;
	localparam int LIMIT_CYCLES = 400000;

	typedef struct packed {
		logic [7:0] data;
		logic       is_last;
	} query_beat_t;

	typedef struct packed {
		logic [7:0] data;
		logic       is_last;
		logic       drop;
	} resp_beat_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  in_byte = 8'h00;
	logic        in_last = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  out_byte;
	logic        out_last;
	logic        out_drop;
	logic        cfg_we = 1'b0;
	logic        cfg_index = REG_ANSWER_ADDRESS;
	logic [31:0] cfg_data = 32'h0;

	captive_dns_responder #(.MAX_MESSAGE(MSG_LIMIT)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_byte(in_byte),
		.in_last(in_last),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_byte(out_byte),
		.out_last(out_last),
		.out_drop(out_drop),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	query_beat_t pending_query[$];
	resp_beat_t  resp_expected[$];
	logic [7:0]  frame_buf[$];

	logic [31:0] ans_addr = ADDRESS_RESET;
	logic [31:0] ans_ttl = TTL_RESET;
	logic [15:0] rsp_pos = 16'h0;
	phase_t      rsp_phase = PH_HEADER;
	logic [7:0]  label_left = 8'h0;
	logic [7:0]  qd_high = 8'h0;
	logic [1:0]  tail_seen = 2'h0;

	logic in_took = 1'b0;
	logic calm = 1'b0;
	int   send_gap = 0;
	int   stall_left = 0;
	int   beats_outstanding = 0;
	int   beats_queued = 0;
	int   frames_queued = 0;
	int   beats_accepted = 0;
	int   resp_seen = 0;
	int   drops_seen = 0;
	int   fail_count = 0;
	int   cycle_count = 0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic logic [7:0] rand_octet();
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic push_resp(input logic [7:0] data, input logic is_last, input logic drop);
		resp_beat_t r;
		r.data = data;
		r.is_last = is_last;
		r.drop = drop;
		resp_expected.push_back(r);
	endtask

	task automatic push_drop(input logic is_last);
		push_resp(8'h00, 1'b1, 1'b1);
		if (is_last) begin
			rsp_phase = PH_HEADER;
			rsp_pos = 16'h0;
		end else begin
			rsp_phase = PH_SWALLOW;
		end
	endtask

	task automatic predict_response(input logic [7:0] b, input logic is_last);
		logic [15:0]  p;
		logic [7:0]   o;
		logic [127:0] rec;
		int           i;
		p = rsp_pos;
		if (rsp_pos != 16'hFFFF)
			rsp_pos = rsp_pos + 16'd1;
		if (rsp_phase == PH_SWALLOW) begin
			if (is_last) begin
				rsp_phase = PH_HEADER;
				rsp_pos = 16'h0;
			end
			return;
		end
		if (rsp_phase == PH_HEADER) begin
			o = b;
			if (is_last) begin
				push_drop(1'b1);
				return;
			end
			if (p == 16'd2)
				o = FLAGS_HI;
			else if (p == 16'd3)
				o = FLAGS_LO;
			else if (p == 16'd6 || (p >= 16'd8 && p <= 16'd11))
				o = 8'h00;
			else if (p == 16'd7)
				o = 8'h01;
			if (p == 16'd4) begin
				qd_high = b;
			end else if (p == 16'd5 && qd_high == 8'h00 && b == 8'h00) begin
				push_drop(1'b0);
				return;
			end
			if (p >= 16'd11)
				rsp_phase = PH_LEN;
			push_resp(o, 1'b0, 1'b0);
			return;
		end
		if (int'(p) + 17 > MSG_LIMIT) begin
			push_drop(is_last);
			return;
		end
		if (rsp_phase == PH_LEN) begin
			if (b == 8'h00) begin
				rsp_phase = PH_TAIL;
				tail_seen = 2'd0;
			end else begin
				label_left = b;
				rsp_phase = PH_LABEL;
			end
		end else if (rsp_phase == PH_LABEL) begin
			label_left = label_left - 8'd1;
			if (label_left == 8'h00)
				rsp_phase = PH_LEN;
		end else begin
			if (tail_seen == 2'd3) begin
				rec = {NAME_PTR_HI, NAME_PTR_LO, 8'h00, RR_TYPE_A, 8'h00, RR_CLASS_IN,
					ans_ttl, 8'h00, RDLENGTH_V4, ans_addr};
				push_resp(b, 1'b0, 1'b0);
				for (i = 0; i < ANSWER_BYTES; i++)
					push_resp(rec[127 - 8 * i -: 8], i == ANSWER_BYTES - 1, 1'b0);
				tail_seen = 2'd0;
				if (is_last) begin
					rsp_phase = PH_HEADER;
					rsp_pos = 16'h0;
				end else begin
					rsp_phase = PH_SWALLOW;
				end
				return;
			end
			tail_seen = tail_seen + 2'd1;
		end
		if (is_last) begin
			push_drop(1'b1);
			return;
		end
		push_resp(b, 1'b0, 1'b0);
	endtask

	// driver: hold the beat until taken, then advance or idle
	always @(negedge clk) begin
		query_beat_t q;
		if (arst_n) begin
			if (in_valid && !in_took) begin
			end else if (send_gap != 0) begin
				in_valid <= 1'b0;
				send_gap = send_gap - 1;
			end else if (pending_query.size() != 0) begin
				q = pending_query.pop_front();
				in_byte <= q.data;
				in_last <= q.is_last;
				in_valid <= 1'b1;
				if (!calm && $urandom_range(0, 5) == 0)
					send_gap = $urandom_range(1, 10);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (calm) begin
				out_ready <= 1'b1;
			end else if (stall_left != 0) begin
				out_ready <= 1'b0;
				stall_left = stall_left - 1;
			end else begin
				out_ready <= 1'b1;
				if ($urandom_range(0, 7) == 0)
					stall_left = $urandom_range(1, 10);
			end
		end
	end

	// monitor: check the response beat, then predict from the query beat
	always @(posedge clk) begin
		resp_beat_t e;
		if (arst_n) begin
			in_took <= in_valid && in_ready;
			if (out_valid && out_ready) begin
				resp_seen++;
				if (out_drop)
					drops_seen++;
				if (resp_expected.size() == 0) begin
					fail_count++;
					$display("%0t unexpected beat: expected none, actual byte %h last %b drop %b",
						$time, out_byte, out_last, out_drop);
				end else begin
					e = resp_expected.pop_front();
					if (out_byte !== e.data) begin
						fail_count++;
						$display("%0t out_byte: expected %h, actual %h", $time, e.data, out_byte);
					end
					if (out_last !== e.is_last) begin
						fail_count++;
						$display("%0t out_last: expected %b, actual %b", $time, e.is_last,
							out_last);
					end
					if (out_drop !== e.drop) begin
						fail_count++;
						$display("%0t out_drop: expected %b, actual %b", $time, e.drop, out_drop);
					end
				end
			end
			if (in_valid && in_ready) begin
				predict_response(in_byte, in_last);
				beats_outstanding--;
				beats_accepted++;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("captive_dns_responder verification failed");
			$finish;
		end
	end

	task automatic commit_frame();
		query_beat_t q;
		int          i;
		for (i = 0; i < frame_buf.size(); i++) begin
			q.data = frame_buf[i];
			q.is_last = (i == frame_buf.size() - 1);
			pending_query.push_back(q);
		end
		beats_outstanding += frame_buf.size();
		beats_queued += frame_buf.size();
		frames_queued++;
		frame_buf.delete();
	endtask

	task automatic add_random(input int n);
		int i;
		for (i = 0; i < n; i++)
			frame_buf.push_back(rand_octet());
	endtask

	task automatic add_header(input logic [15:0] qd);
		add_random(4);
		frame_buf.push_back(qd[15:8]);
		frame_buf.push_back(qd[7:0]);
		add_random(6);
	endtask

	task automatic add_label(input int len);
		frame_buf.push_back(8'(len));
		add_random(len);
	endtask

	task automatic add_question(input int labels, input int max_len);
		int l;
		for (l = 0; l < labels; l++)
			add_label($urandom_range(1, max_len));
		frame_buf.push_back(8'h00);
		add_random(4);
	endtask

	function automatic logic [15:0] rand_qd();
		logic [15:0] qd;
		case ($urandom_range(0, 3))
			0: qd = {8'h00, 8'($urandom_range(1, 255))};
			1: qd = {8'($urandom_range(1, 255)), 8'h00};
			default: begin
				qd = 16'($urandom_range(0, 65535));
				if (qd == 16'h0)
					qd = 16'h1;
			end
		endcase
		return qd;
	endfunction

	task automatic run_random(input int n);
		int target;
		int kind;
		int cut;
		target = beats_queued + n;
		while (beats_queued < target) begin
			kind = $urandom_range(0, 99);
			if (kind < 60) begin
				add_header(rand_qd());
				add_question($urandom_range(0, 3), ($urandom_range(0, 9) == 0) ? 63 : 12);
				add_random($urandom_range(0, 3));
			end else if (kind < 72) begin
				add_header(rand_qd());
				add_question($urandom_range(0, 3), 12);
				cut = $urandom_range(12, frame_buf.size() - 1);
				while (frame_buf.size() > cut)
					void'(frame_buf.pop_back());
			end else if (kind < 82) begin
				add_random($urandom_range(1, 11));
			end else if (kind < 88) begin
				add_header(16'h0000);
				add_random($urandom_range(0, 4));
				cut = $urandom_range(6, frame_buf.size());
				while (frame_buf.size() > cut)
					void'(frame_buf.pop_back());
			end else begin
				add_random($urandom_range(1, 30));
			end
			commit_frame();
		end
	endtask

	task automatic wait_drain();
		do
			@(negedge clk);
		while (beats_outstanding != 0 || resp_expected.size() != 0);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [31:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_ANSWER_ADDRESS)
			ans_addr = value;
		else
			ans_ttl = value;
	endtask

	initial begin
		int i;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// single-byte frame
		frame_buf.push_back(8'hFF);
		commit_frame();
		// zero question count, all-zero bytes
		for (i = 0; i < 7; i++)
			frame_buf.push_back(8'h00);
		commit_frame();
		// root-name question, all-ones header and tail
		for (i = 0; i < 12; i++)
			frame_buf.push_back(8'hFF);
		frame_buf.push_back(8'h00);
		for (i = 0; i < 4; i++)
			frame_buf.push_back(8'hFF);
		commit_frame();
		wait_drain();

		write_reg(REG_ANSWER_ADDRESS, 32'h0000_0000);
		write_reg(REG_ANSWER_TTL, 32'h0000_0000);
		run_random(30);
		wait_drain();

		write_reg(REG_ANSWER_ADDRESS, 32'hFFFF_FFFF);
		write_reg(REG_ANSWER_TTL, 32'hFFFF_FFFF);
		run_random(30);
		wait_drain();

		write_reg(REG_ANSWER_TTL, 32'($urandom));
		write_reg(REG_ANSWER_ADDRESS, 32'($urandom));
		add_header(rand_qd());
		add_label(192);
		frame_buf.push_back(8'h00);
		add_random(6);
		commit_frame();
		run_random(10);
		wait_drain();

		write_reg(REG_ANSWER_ADDRESS, 32'($urandom));
		write_reg(REG_ANSWER_TTL, 32'($urandom));
		calm = 1'b1;
		run_random(30);
		wait_drain();
		repeat (20) @(negedge clk);

		if (resp_expected.size() != 0) begin
			fail_count++;
			$display("%0t leftover: expected %0d more beats, actual none", $time,
				resp_expected.size());
		end
		$display("Ran %0d query beats in %0d frames over five answer settings,", beats_accepted,
			frames_queued);
		$display("checking %0d response beats, %0d of them drop markers.", resp_seen, drops_seen);
		if (fail_count == 0)
			$display("captive_dns_responder verification clean");
		else
			$display("captive_dns_responder verification failed");
		$finish;
	end

endmodule

FILE: filelist.f
sv/cdr_pkg.sv
sv/cdr_parse.sv
sv/captive_dns_responder.sv
tb/captive_dns_responder_test.sv
